// File: rtl/irpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IR remote pulse decoder package
// Shared types, register indexes and reset values for the decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int FrameIntervalsDefault = 65;
   localparam int FrameBitsWidth        = 32;
   localparam int CsrIndexWidth         = 3;
   localparam int CsrDataWidth          = 8;

   localparam logic [7:0] ToggleKey = 8'd64;

   // Reset values of the timing windows, in 0.1 ms units.
   localparam logic [7:0] LeaderLowReset  = 8'd70;
   localparam logic [7:0] LeaderHighReset = 8'd100;
   localparam logic [7:0] StartLowReset   = 8'd30;
   localparam logic [7:0] StartHighReset  = 8'd55;
   localparam logic [7:0] RepeatLowReset  = 8'd15;
   localparam logic [7:0] RepeatHighReset = 8'd30;
   localparam logic [7:0] OneLowReset     = 8'd10;
   localparam logic [7:0] OneHighReset    = 8'd20;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LEADER_LOW  = 3'd0,
      CSR_LEADER_HIGH = 3'd1,
      CSR_START_LOW   = 3'd2,
      CSR_START_HIGH  = 3'd3,
      CSR_REPEAT_LOW  = 3'd4,
      CSR_REPEAT_HIGH = 3'd5,
      CSR_ONE_LOW     = 3'd6,
      CSR_ONE_HIGH    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_VALID  = 2'd1,
      EV_FAILED = 2'd2,
      EV_REPEAT = 2'd3
   } event_type;

   typedef struct packed {
      logic [7:0] leader_low;
      logic [7:0] leader_high;
      logic [7:0] start_low;
      logic [7:0] start_high;
      logic [7:0] repeat_low;
      logic [7:0] repeat_high;
      logic [7:0] one_low;
      logic [7:0] one_high;
   } cfg_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] key_code;
      logic [7:0] address_high;
      logic [7:0] address_low;
      logic       remote_enabled;
   } result_type;

   // Open window test: low < x < high.
   function automatic logic in_window(logic [7:0] x, logic [7:0] lo, logic [7:0] hi);
      in_window = (x > lo) && (x < hi);
   endfunction

endpackage
`default_nettype wire

// File: rtl/irpd_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IR remote pulse decoder channels
// Valid/ready interfaces for the interval input and the decoded result.
// ----------------------------------------------------------------------------
interface irpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] interval;

   modport source (output valid, output interval, input ready);
   modport sink   (input valid, input interval, output ready);
endinterface

interface irpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic [7:0] key_code;
   logic [7:0] address_high;
   logic [7:0] address_low;
   logic       remote_enabled;

   modport source (output valid, output event_res, output key_code,
                   output address_high, output address_low,
                   output remote_enabled, input ready);
   modport sink   (input valid, input event_res, input key_code,
                   input address_high, input address_low,
                   input remote_enabled, output ready);
endinterface
`default_nettype wire

// File: rtl/irpd_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IR remote pulse decoder step logic
// Next decoder state and the result for one edge interval.
// ----------------------------------------------------------------------------
module irpd_step #(
   parameter int FRAME_INTERVALS = irpd_pkg::FrameIntervalsDefault,
   parameter int CountWidth      = $clog2(FRAME_INTERVALS + 1)
) (
   input  wire irpd_pkg::cfg_type                      cfg,
   input  wire logic [7:0]                             interval,
   input  wire logic                                   leader_seen,
   input  wire logic                                   collecting,
   input  wire logic [CountWidth-1:0]                  interval_count,
   input  wire logic [7:0]                             pair_first,
   input  wire logic [irpd_pkg::FrameBitsWidth-1:0]    frame_bits,
   input  wire logic [7:0]                             last_key,
   input  wire logic                                   enable_flag,
   output logic                                        leader_seen_in,
   output logic                                        collecting_in,
   output logic [CountWidth-1:0]                       interval_count_in,
   output logic [7:0]                                  pair_first_in,
   output logic [irpd_pkg::FrameBitsWidth-1:0]         frame_bits_in,
   output logic [7:0]                                  last_key_in,
   output logic                                        enable_flag_in,
   output irpd_pkg::result_type                        result
);

   logic [CountWidth-1:0] count_inc;
   logic [7:0]            pair_sum;

   always_comb begin
      leader_seen_in    = leader_seen;
      collecting_in     = collecting;
      interval_count_in = interval_count;
      pair_first_in     = pair_first;
      frame_bits_in     = frame_bits;
      last_key_in       = last_key;
      enable_flag_in    = enable_flag;
      result            = '0;
      pair_sum          = pair_first + interval;
      count_inc         = '0;

      // Leader wins over start, start over repeat.
      if (irpd_pkg::in_window(interval, cfg.leader_low, cfg.leader_high)) begin
         leader_seen_in = 1'b1;
      end else if (leader_seen &&
                   irpd_pkg::in_window(interval, cfg.start_low, cfg.start_high)) begin
         collecting_in     = 1'b1;
         leader_seen_in    = 1'b0;
         interval_count_in = '0;
         frame_bits_in     = '0;
      end else if (leader_seen &&
                   irpd_pkg::in_window(interval, cfg.repeat_low, cfg.repeat_high)) begin
         collecting_in    = 1'b0;
         leader_seen_in   = 1'b0;
         result.event_res = irpd_pkg::EV_REPEAT;
         result.key_code  = last_key;
      end

      if (collecting_in) begin
         // Odd intervals are stored, even nonzero ones close a pair and yield a bit.
         if (interval_count_in != '0) begin
            if (interval_count_in[0]) begin
               pair_first_in = interval;
            end else begin
               frame_bits_in = {frame_bits_in[irpd_pkg::FrameBitsWidth-2:0],
                                irpd_pkg::in_window(pair_sum, cfg.one_low, cfg.one_high)};
            end
         end
         count_inc = interval_count_in + 1'b1;
         if (count_inc == CountWidth'(FRAME_INTERVALS)) begin
            interval_count_in   = '0;
            collecting_in       = 1'b0;
            result.address_high = frame_bits_in[31:24];
            result.address_low  = frame_bits_in[23:16];
            if ((frame_bits_in[23:16] == ~frame_bits_in[31:24]) &&
                (frame_bits_in[7:0] == ~frame_bits_in[15:8])) begin
               result.event_res = irpd_pkg::EV_VALID;
               result.key_code  = frame_bits_in[15:8];
            end else begin
               result.event_res = irpd_pkg::EV_FAILED;
               result.key_code  = '0;
            end
            last_key_in = result.key_code;
            if (result.key_code == irpd_pkg::ToggleKey) begin
               enable_flag_in = ~enable_flag;
            end
         end else begin
            interval_count_in = count_inc;
         end
      end

      result.remote_enabled = enable_flag_in;
   end

endmodule
`default_nettype wire

// File: rtl/ir_remote_pulse_decoder.sv
// An accepted item is held in the input register, then decoded into the
// result register, from which its result leaves on the response channel.
// Throughput: one item per cycle while results are taken; the decoder state
// is updated in a single pass between the input and result registers.
// Reset (synchronous, active high) arms nothing, stops any frame, clears the
// last key, sets the enable flag and loads the default timing windows.
`default_nettype none
// ----------------------------------------------------------------------------
// IR remote pulse decoder
// Decodes NEC-style remote frames from a stream of edge-to-edge intervals.
// ----------------------------------------------------------------------------
module ir_remote_pulse_decoder #(
   parameter int FRAME_INTERVALS = irpd_pkg::FrameIntervalsDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   irpd_req_if.sink                                req_chan,
   irpd_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_write_enable,
   input  wire logic [irpd_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [irpd_pkg::CsrDataWidth-1:0]  csr_write_data
);

   localparam int CountWidth = $clog2(FRAME_INTERVALS + 1);

   // Configuration registers holding the timing windows.
   irpd_pkg::cfg_type cfg_ff;

   // Input register: one interval waiting to be decoded.
   logic       in_valid_ff;
   logic [7:0] in_interval_ff;

   // Decoder state.
   logic                                   leader_seen_ff, leader_seen_in;
   logic                                   collecting_ff, collecting_in;
   logic [CountWidth-1:0]                  interval_count_ff, interval_count_in;
   logic [7:0]                             pair_first_ff, pair_first_in;
   logic [irpd_pkg::FrameBitsWidth-1:0]    frame_bits_ff, frame_bits_in;
   logic [7:0]                             last_key_ff, last_key_in;
   logic                                   enable_flag_ff, enable_flag_in;

   // Result register.
   logic                 out_valid_ff;
   irpd_pkg::result_type out_result_ff;
   irpd_pkg::result_type step_result;

   logic advance;

   // The held interval is decoded whenever the result register is free or is
   // being emptied in this same cycle. The input register then frees up, so a
   // new item can enter every cycle while results flow.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.event_res      = out_result_ff.event_res;
   assign rsp_chan.key_code       = out_result_ff.key_code;
   assign rsp_chan.address_high   = out_result_ff.address_high;
   assign rsp_chan.address_low    = out_result_ff.address_low;
   assign rsp_chan.remote_enabled = out_result_ff.remote_enabled;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_low  <= irpd_pkg::LeaderLowReset;
         cfg_ff.leader_high <= irpd_pkg::LeaderHighReset;
         cfg_ff.start_low   <= irpd_pkg::StartLowReset;
         cfg_ff.start_high  <= irpd_pkg::StartHighReset;
         cfg_ff.repeat_low  <= irpd_pkg::RepeatLowReset;
         cfg_ff.repeat_high <= irpd_pkg::RepeatHighReset;
         cfg_ff.one_low     <= irpd_pkg::OneLowReset;
         cfg_ff.one_high    <= irpd_pkg::OneHighReset;
      end else if (csr_write_enable) begin
         unique case (irpd_pkg::csr_index_type'(csr_index))
            irpd_pkg::CSR_LEADER_LOW:  cfg_ff.leader_low  <= csr_write_data;
            irpd_pkg::CSR_LEADER_HIGH: cfg_ff.leader_high <= csr_write_data;
            irpd_pkg::CSR_START_LOW:   cfg_ff.start_low   <= csr_write_data;
            irpd_pkg::CSR_START_HIGH:  cfg_ff.start_high  <= csr_write_data;
            irpd_pkg::CSR_REPEAT_LOW:  cfg_ff.repeat_low  <= csr_write_data;
            irpd_pkg::CSR_REPEAT_HIGH: cfg_ff.repeat_high <= csr_write_data;
            irpd_pkg::CSR_ONE_LOW:     cfg_ff.one_low     <= csr_write_data;
            irpd_pkg::CSR_ONE_HIGH:    cfg_ff.one_high    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   irpd_step #(
      .FRAME_INTERVALS (FRAME_INTERVALS),
      .CountWidth      (CountWidth)
   ) u_step (
      .cfg               (cfg_ff),
      .interval          (in_interval_ff),
      .leader_seen       (leader_seen_ff),
      .collecting        (collecting_ff),
      .interval_count    (interval_count_ff),
      .pair_first        (pair_first_ff),
      .frame_bits        (frame_bits_ff),
      .last_key          (last_key_ff),
      .enable_flag       (enable_flag_ff),
      .leader_seen_in    (leader_seen_in),
      .collecting_in     (collecting_in),
      .interval_count_in (interval_count_in),
      .pair_first_in     (pair_first_in),
      .frame_bits_in     (frame_bits_in),
      .last_key_in       (last_key_in),
      .enable_flag_in    (enable_flag_in),
      .result            (step_result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_interval_ff <= req_chan.interval;
      end
   end

   // Decoder state moves only when an interval is actually decoded.
   always_ff @(posedge clock) begin
      if (reset) begin
         leader_seen_ff    <= 1'b0;
         collecting_ff     <= 1'b0;
         interval_count_ff <= '0;
         frame_bits_ff     <= '0;
         last_key_ff       <= '0;
         enable_flag_ff    <= 1'b1;
      end else if (advance) begin
         leader_seen_ff    <= leader_seen_in;
         collecting_ff     <= collecting_in;
         interval_count_ff <= interval_count_in;
         frame_bits_ff     <= frame_bits_in;
         last_key_ff       <= last_key_in;
         enable_flag_ff    <= enable_flag_in;
      end
   end

   // The first interval of a pair is always written before it is read.
   always_ff @(posedge clock) begin
      if (advance) begin
         pair_first_ff <= pair_first_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

endmodule
`default_nettype wire
